// ===== src/cdm_pkg.sv =====
// ----------------------------------------------------------------------------
// cdm_pkg: shared types and constants for the concentric disk map unit
// Angle format: 2^29 units = pi/4, CORDIC datapath in Q.30.
// ----------------------------------------------------------------------------
package cdm_pkg;

  localparam int QuoBits = 30;   // ratio quotient, 2^29 = 1.0
  localparam int AngBits = 34;   // signed angle before quadrant reduction
  localparam int CorBits = 33;   // signed CORDIC x, y, z

  localparam logic [29:0]         KGain     = 30'h26DD3B6A;
  localparam logic [AngBits-1:0]  QuarterPi = 34'h0_2000_0000;

  // Wedge decision that travels with the divider
  typedef struct packed {
    logic [1:0] quad;   // base angle in units of pi/2
    logic       sub;    // subtract the ratio from the base
    logic       neg;    // numerator and denominator differ in sign
    logic       zero;   // center point, angle forced to zero
  } wedge_t;

  function automatic logic [29:0] atan_lut(input int unsigned idx);
    logic [29:0] val;
    case (idx)
      0:       val = 30'h20000000;
      1:       val = 30'h12E4051E;
      2:       val = 30'h09FB385B;
      3:       val = 30'h051111D4;
      4:       val = 30'h028B0D43;
      5:       val = 30'h0145D7E1;
      6:       val = 30'h00A2F61E;
      7:       val = 30'h00517C55;
      8:       val = 30'h0028BE53;
      9:       val = 30'h00145F2F;
      10:      val = 30'h000A2F98;
      11:      val = 30'h000517CC;
      12:      val = 30'h00028BE6;
      13:      val = 30'h000145F3;
      14:      val = 30'h0000A2F9;
      15:      val = 30'h0000517C;
      16:      val = 30'h000028BE;
      17:      val = 30'h0000145F;
      18:      val = 30'h00000A2F;
      19:      val = 30'h00000517;
      20:      val = 30'h0000028B;
      21:      val = 30'h00000145;
      22:      val = 30'h000000A2;
      default: val = 30'h00000051;
    endcase
    return val;
  endfunction

endpackage

// ===== src/cdm_wedge.sv =====
// ----------------------------------------------------------------------------
// cdm_wedge: wedge selection
// Maps (u,v) to (a,b) on [-1,1)^2 and picks radius, ratio operands and base.
// ----------------------------------------------------------------------------
module cdm_wedge import cdm_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [SAMPLE_BITS-1:0] u_i,
  input  logic [SAMPLE_BITS-1:0] v_i,
  output logic                   valid_o,
  output logic [SAMPLE_BITS:0]   r_o,
  output logic [SAMPLE_BITS:0]   num_o,
  output logic [SAMPLE_BITS:0]   den_o,
  output wedge_t                 info_o
);

  localparam int S = SAMPLE_BITS;

  logic signed [S+2:0] a, b, na, nb;
  logic [S:0]          abs_a, abs_b;
  logic [S:0]          r_d, num_d, den_d;
  wedge_t              info_d;
  logic                valid_q;
  logic [S:0]          r_q, num_q, den_q;
  wedge_t              info_q;

  always_comb begin
    a     = signed'({2'b00, u_i, 1'b0}) - signed'({3'b001, {S{1'b0}}});
    b     = signed'({2'b00, v_i, 1'b0}) - signed'({3'b001, {S{1'b0}}});
    na    = -a;
    nb    = -b;
    abs_a = a[S+2] ? na[S:0] : a[S:0];
    abs_b = b[S+2] ? nb[S:0] : b[S:0];
    info_d.neg  = a[S+2] ^ b[S+2];
    info_d.zero = 1'b0;
    if (a > nb) begin
      if (a > b) begin
        r_d = a[S:0];  num_d = abs_b; den_d = abs_a;
        info_d.quad = 2'd0; info_d.sub = 1'b0;
      end else begin
        r_d = b[S:0];  num_d = abs_a; den_d = abs_b;
        info_d.quad = 2'd1; info_d.sub = 1'b1;
      end
    end else begin
      if (a < b) begin
        r_d = na[S:0]; num_d = abs_b; den_d = abs_a;
        info_d.quad = 2'd2; info_d.sub = 1'b0;
      end else begin
        r_d = nb[S:0]; num_d = abs_a; den_d = abs_b;
        info_d.quad = 2'd3; info_d.sub = 1'b1;
        info_d.zero = (b == '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q    <= r_d;
      num_q  <= num_d;
      den_q  <= den_d;
      info_q <= info_d;
    end
  end

  assign valid_o = valid_q;
  assign r_o     = r_q;
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign info_o  = info_q;

endmodule

// ===== src/cdm_div.sv =====
// ----------------------------------------------------------------------------
// cdm_div: pipelined restoring divider
// Forms (num * 2^29) / den, one quotient bit per stage, num <= den.
// ----------------------------------------------------------------------------
module cdm_div import cdm_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [SAMPLE_BITS:0]   r_i,
  input  logic [SAMPLE_BITS:0]   num_i,
  input  logic [SAMPLE_BITS:0]   den_i,
  input  wedge_t                 info_i,
  output logic                   valid_o,
  output logic [SAMPLE_BITS:0]   r_o,
  output logic [QuoBits-1:0]     quo_o,
  output wedge_t                 info_o
);

  localparam int S = SAMPLE_BITS;
  localparam int W = S + 2;

  logic               vld_w  [QuoBits+1];
  logic [W-1:0]       rem_w  [QuoBits+1];
  logic [S:0]         den_w  [QuoBits+1];
  logic [S:0]         r_w    [QuoBits+1];
  logic [QuoBits-1:0] quo_w  [QuoBits+1];
  wedge_t             info_w [QuoBits+1];

  assign vld_w[0]  = valid_i;
  assign rem_w[0]  = {1'b0, num_i};
  assign den_w[0]  = den_i;
  assign r_w[0]    = r_i;
  assign quo_w[0]  = '0;
  assign info_w[0] = info_i;

  for (genvar s = 0; s < QuoBits; s++) begin : g_step
    logic               ge;
    logic [W-1:0]       diff;
    logic               vld_q;
    logic [W-1:0]       rem_q;
    logic [S:0]         den_q, r_q;
    logic [QuoBits-1:0] quo_q;
    wedge_t             info_q;

    assign ge   = rem_w[s] >= {1'b0, den_w[s]};
    assign diff = ge ? rem_w[s] - {1'b0, den_w[s]} : rem_w[s];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_w[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= {diff[W-2:0], 1'b0};
        den_q  <= den_w[s];
        r_q    <= r_w[s];
        quo_q  <= {quo_w[s][QuoBits-2:0], ge};
        info_q <= info_w[s];
      end
    end

    assign vld_w[s+1]  = vld_q;
    assign rem_w[s+1]  = rem_q;
    assign den_w[s+1]  = den_q;
    assign r_w[s+1]    = r_q;
    assign quo_w[s+1]  = quo_q;
    assign info_w[s+1] = info_q;
  end

  assign valid_o = vld_w[QuoBits];
  assign r_o     = r_w[QuoBits];
  assign quo_o   = quo_w[QuoBits];
  assign info_o  = info_w[QuoBits];

endmodule

// ===== src/cdm_cordic.sv =====
// ----------------------------------------------------------------------------
// cdm_cordic: angle assembly and pipelined rotation CORDIC
// Reduces the angle to [-pi/4, pi/4), rotates, turns by quarter turns, rounds.
// ----------------------------------------------------------------------------
module cdm_cordic import cdm_pkg::*; #(
  parameter int SAMPLE_BITS   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [SAMPLE_BITS:0]   r_i,
  input  logic [QuoBits-1:0]     quo_i,
  input  wedge_t                 info_i,
  output logic                   valid_o,
  output logic signed [15:0]     x_o,
  output logic signed [15:0]     y_o
);

  localparam int S = SAMPLE_BITS;

  logic signed [AngBits-1:0] qs, t, tq, z0;
  logic [S+30:0]             prod;
  logic                      vp_q;
  logic [29:0]               xp_q;
  logic signed [CorBits-1:0] zp_q;
  logic [1:0]                np_q;

  always_comb begin
    qs = signed'({{(AngBits-QuoBits){1'b0}}, quo_i});
    t  = signed'({2'b00, info_i.quad, 30'b0}) + ((info_i.neg ^ info_i.sub) ? -qs : qs);
    if (info_i.zero) begin
      t = '0;
    end
    tq   = t + signed'(QuarterPi);
    z0   = signed'({{(AngBits-30){1'b0}}, tq[29:0]}) - signed'(QuarterPi);
    prod = {{30{1'b0}}, r_i} * {{(S+1){1'b0}}, KGain};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (en_i) begin
      vp_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xp_q <= prod[S+29:S];
      zp_q <= z0[CorBits-1:0];
      np_q <= tq[31:30];
    end
  end

  logic                      v_w [CORDIC_STAGES+1];
  logic signed [CorBits-1:0] x_w [CORDIC_STAGES+1];
  logic signed [CorBits-1:0] y_w [CORDIC_STAGES+1];
  logic signed [CorBits-1:0] z_w [CORDIC_STAGES+1];
  logic [1:0]                n_w [CORDIC_STAGES+1];

  assign v_w[0] = vp_q;
  assign x_w[0] = signed'({{(CorBits-30){1'b0}}, xp_q});
  assign y_w[0] = '0;
  assign z_w[0] = zp_q;
  assign n_w[0] = np_q;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
    logic signed [CorBits-1:0] dx, dy, ang;
    logic                      v_q;
    logic signed [CorBits-1:0] x_q, y_q, z_q;
    logic [1:0]                n_q;

    assign dx  = x_w[i] >>> i;
    assign dy  = y_w[i] >>> i;
    assign ang = signed'({{(CorBits-30){1'b0}}, atan_lut(i)});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= v_w[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_w[i][CorBits-1]) begin
          x_q <= x_w[i] - dy;
          y_q <= y_w[i] + dx;
          z_q <= z_w[i] - ang;
        end else begin
          x_q <= x_w[i] + dy;
          y_q <= y_w[i] - dx;
          z_q <= z_w[i] + ang;
        end
        n_q <= n_w[i];
      end
    end

    assign v_w[i+1] = v_q;
    assign x_w[i+1] = x_q;
    assign y_w[i+1] = y_q;
    assign z_w[i+1] = z_q;
    assign n_w[i+1] = n_q;
  end

  function automatic logic signed [15:0] round_sat(input logic signed [CorBits-1:0] val);
    logic signed [CorBits:0] sh;
    logic signed [15:0]      res;
    sh = (signed'({val[CorBits-1], val}) + signed'((CorBits+1)'(16384))) >>> 15;
    if (sh > signed'((CorBits+1)'(32767))) begin
      res = 16'sh7FFF;
    end else if (sh < -signed'((CorBits+1)'(32768))) begin
      res = 16'sh8000;
    end else begin
      res = sh[15:0];
    end
    return res;
  endfunction

  logic signed [CorBits-1:0] xr, yr, xf, yf;
  logic                      vo_q;
  logic signed [15:0]        xo_q, yo_q;

  always_comb begin
    xf = x_w[CORDIC_STAGES];
    yf = y_w[CORDIC_STAGES];
    case (n_w[CORDIC_STAGES])
      2'd0:    begin xr = xf;  yr = yf;  end
      2'd1:    begin xr = -yf; yr = xf;  end
      2'd2:    begin xr = -xf; yr = -yf; end
      default: begin xr = yf;  yr = -xf; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= v_w[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xo_q <= round_sat(xr);
      yo_q <= round_sat(yr);
    end
  end

  assign valid_o = vo_q;
  assign x_o     = xo_q;
  assign y_o     = yo_q;

endmodule

// ===== src/cdm_lift.sv =====
// ----------------------------------------------------------------------------
// cdm_lift: hemisphere height
// Squares, radicand, then a pipelined bit-pair square root.
// ----------------------------------------------------------------------------
module cdm_lift import cdm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [15:0] x_i,
  input  logic signed [15:0] y_i,
  input  logic               mode_i,
  output logic               valid_o,
  output logic signed [15:0] x_o,
  output logic signed [15:0] y_o,
  output logic [14:0]        z_o
);

  localparam int Roots = 16;

  logic               v1_q, v2_q;
  logic signed [31:0] xx_q, yy_q;
  logic signed [15:0] x1_q, y1_q, x2_q, y2_q;
  logic signed [33:0] rem;
  logic [30:0]        rad_q;

  always_comb begin
    rem = signed'(34'h0_4000_0000) - signed'({{2{xx_q[31]}}, xx_q})
        - signed'({{2{yy_q[31]}}, yy_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xx_q  <= x_i * x_i;
      yy_q  <= y_i * y_i;
      x1_q  <= x_i;
      y1_q  <= y_i;
      rad_q <= (rem > 0) ? rem[30:0] : '0;
      x2_q  <= x1_q;
      y2_q  <= y1_q;
    end
  end

  logic               v_w   [Roots+1];
  logic [30:0]        rv_w  [Roots+1];
  logic [31:0]        res_w [Roots+1];
  logic signed [15:0] x_w   [Roots+1];
  logic signed [15:0] y_w   [Roots+1];

  assign v_w[0]   = v2_q;
  assign rv_w[0]  = rad_q;
  assign res_w[0] = '0;
  assign x_w[0]   = x2_q;
  assign y_w[0]   = y2_q;

  for (genvar i = 0; i < Roots; i++) begin : g_root
    logic [31:0]        bitv, sum;
    logic               ge;
    logic               v_q;
    logic [30:0]        rv_q;
    logic [31:0]        res_q;
    logic signed [15:0] x_q, y_q;

    assign bitv = 32'(1) << (30 - 2 * i);
    assign sum  = res_w[i] + bitv;
    assign ge   = {1'b0, rv_w[i]} >= sum;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= v_w[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rv_q  <= ge ? rv_w[i] - sum[30:0] : rv_w[i];
        res_q <= ge ? (res_w[i] >> 1) + bitv : res_w[i] >> 1;
        x_q   <= x_w[i];
        y_q   <= y_w[i];
      end
    end

    assign v_w[i+1]   = v_q;
    assign rv_w[i+1]  = rv_q;
    assign res_w[i+1] = res_q;
    assign x_w[i+1]   = x_q;
    assign y_w[i+1]   = y_q;
  end

  logic [14:0] z_sat;

  // the root reaches 2^15 only at the center point: clamp it
  assign z_sat   = (res_w[Roots][31:15] != '0) ? 15'h7FFF : res_w[Roots][14:0];
  assign z_o     = mode_i ? z_sat : '0;
  assign valid_o = v_w[Roots];
  assign x_o     = x_w[Roots];
  assign y_o     = y_w[Roots];

endmodule

// ===== src/concentric_disk_map_unit.sv =====
// ----------------------------------------------------------------------------
// concentric_disk_map_unit: square-to-disk sample warp with hemisphere lift
// Maps a unit-square sample to the unit disk and optionally to a hemisphere.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_ready_o carry sample_u_i and sample_v_i,
// unsigned Q0.SAMPLE_BITS. Output channel: out_valid_o / out_ready_i carry
// disk_x_o, disk_y_o (signed Q1.15) and lift_z_o (unsigned Q0.15, zero
// unless the hemisphere bit is set). cfg_we_i writes cfg_wdata_i into the
// hemisphere bit at once; write it only while no sample is in flight.
// Throughput: one sample per cycle while the output is not stalled. A sample
// goes from transfer in to result valid through, among other registers, the
// wedge register, the 30-stage ratio divider, one CORDIC stage per
// micro-rotation and the 16-stage square root.
// Every stage advances together: while a result waits on the output with
// out_ready_i low, the whole pipeline holds and in_ready_o drops, so nothing
// is lost or repeated. Reset clears all valid bits and the hemisphere bit.
// ----------------------------------------------------------------------------
module concentric_disk_map_unit import cdm_pkg::*; #(
  parameter int SAMPLE_BITS   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_u_i,
  input  logic [SAMPLE_BITS-1:0] sample_v_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [15:0]     disk_x_o,
  output logic signed [15:0]     disk_y_o,
  output logic [14:0]            lift_z_o
);

  logic                   en;
  logic                   mode_q;
  logic                   w_valid, d_valid, c_valid;
  logic [SAMPLE_BITS:0]   w_r, w_num, w_den, d_r;
  wedge_t                 w_info, d_info;
  logic [QuoBits-1:0]     d_quo;
  logic signed [15:0]     c_x, c_y;

  // advance all stages unless a result is stuck at the output
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  cdm_wedge #(.SAMPLE_BITS(SAMPLE_BITS)) u_wedge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .u_i     (sample_u_i),
    .v_i     (sample_v_i),
    .valid_o (w_valid),
    .r_o     (w_r),
    .num_o   (w_num),
    .den_o   (w_den),
    .info_o  (w_info)
  );

  cdm_div #(.SAMPLE_BITS(SAMPLE_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (w_valid),
    .r_i     (w_r),
    .num_i   (w_num),
    .den_i   (w_den),
    .info_i  (w_info),
    .valid_o (d_valid),
    .r_o     (d_r),
    .quo_o   (d_quo),
    .info_o  (d_info)
  );

  cdm_cordic #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_valid),
    .r_i     (d_r),
    .quo_i   (d_quo),
    .info_i  (d_info),
    .valid_o (c_valid),
    .x_o     (c_x),
    .y_o     (c_y)
  );

  cdm_lift u_lift (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (c_valid),
    .x_i     (c_x),
    .y_i     (c_y),
    .mode_i  (mode_q),
    .valid_o (out_valid_o),
    .x_o     (disk_x_o),
    .y_o     (disk_y_o),
    .z_o     (lift_z_o)
  );

endmodule

// ===== src/cdm_checker.sv =====
// ----------------------------------------------------------------------------
// cdm_checker: port-level checks for the concentric disk map unit
// Watches the handshakes, stall behavior and the hemisphere output.
// ----------------------------------------------------------------------------
module cdm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input logic               cfg_wdata_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] disk_x_o,
  input logic signed [15:0] disk_y_o,
  input logic [14:0]        lift_z_o
);

  logic mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(disk_x_o)
      && $stable(disk_y_o) && $stable(lift_z_o))
    else $error("output changed while stalled");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");

  a_empty_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input refused with empty output");

  a_flat_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !mode_q |-> lift_z_o == '0)
    else $error("height given outside hemisphere mode");

  a_pole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_q && disk_x_o == '0 && disk_y_o == '0 |-> lift_z_o == 15'h7FFF)
    else $error("center point not lifted to the pole");

endmodule

bind concentric_disk_map_unit cdm_checker u_cdm_checker (.*);

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: regression for concentric_disk_map_unit
// Streams unit-square samples through the disk map under random idling and a
// long output hold-off, predicts every disk point and hemisphere height with
// a fixed-point model of the wedge, ratio and CORDIC steps, and checks each
// transfer out in order. The hemisphere bit is written between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import cdm_pkg::*;

  localparam int SampleBits  = 16;
  localparam int CordicSteps = 16;
  localparam int Latency     = 51 + CordicSteps;
  localparam int WatchLimit  = 2000;
  localparam int HoldCycles  = 300;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        z;
  } disk_pt_t;

  typedef struct {
    logic [15:0] u;
    logic [15:0] v;
    logic        known;
    disk_pt_t    pt;
  } stim_row_t;

  logic clk_i, rst_ni;
  logic cfg_we_i, cfg_wdata_i;
  logic in_valid_i, in_ready_o;
  logic [SampleBits-1:0] sample_u_i, sample_v_i;
  logic out_valid_o, out_ready_i;
  logic signed [15:0] disk_x_o, disk_y_o;
  logic [14:0] lift_z_o;

  concentric_disk_map_unit #(
    .SAMPLE_BITS  (SampleBits),
    .CORDIC_STAGES(CordicSteps)
  ) dut (.*);

  disk_pt_t    pending_pts[$];
  int          mismatches = 0;
  logic        hemi_bit = 1'b0;
  bit          calm = 1'b0;
  bit          hold_out = 1'b0;
  bit          drive_done = 1'b0;
  int          idle_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint shift_floor(longint val, int sh);
    return val >>> sh;
  endfunction

  function automatic longint wedge_ratio(longint num, longint den);
    longint n, d, q;
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    if (d == 0) return 0;
    q = (n << 29) / d;
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic longint clamp16(longint val);
    if (val > 32767) return 32767;
    if (val < -32768) return -32768;
    return val;
  endfunction

  function automatic longint int_sqrt(longint val);
    longint res, bitv;
    res = 0;
    bitv = 64'sd1 << 62;
    while (bitv > val) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (val >= res + bitv) begin
        val = val - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic disk_pt_t map_to_disk(logic [15:0] u, logic [15:0] v, logic hemi);
    longint a, b, r, ang, nq, x, y, zr, dx, dy, tmp, xo, yo, rad, hz;
    disk_pt_t pt;
    a = 2 * longint'(u) - (64'sd1 << SampleBits);
    b = 2 * longint'(v) - (64'sd1 << SampleBits);
    if (a > -b) begin
      if (a > b) begin
        r = a; ang = wedge_ratio(b, a);
      end else begin
        r = b; ang = 2 * longint'(QuarterPi) - wedge_ratio(a, b);
      end
    end else if (a < b) begin
      r = -a; ang = 4 * longint'(QuarterPi) + wedge_ratio(b, a);
    end else begin
      r = -b;
      ang = (b != 0) ? 6 * longint'(QuarterPi) - wedge_ratio(a, b) : 0;
    end
    nq = (ang + longint'(QuarterPi)) >>> 30;
    zr = ang - nq * 2 * longint'(QuarterPi);
    nq = nq & 3;
    x = ((r << (30 - SampleBits)) * longint'(KGain)) >>> 30;
    y = 0;
    for (int i = 0; i < CordicSteps; i++) begin
      dx = shift_floor(y, i);
      dy = shift_floor(x, i);
      if (zr >= 0) begin
        x -= dx; y += dy; zr -= longint'(atan_lut(i));
      end else begin
        x += dx; y -= dy; zr += longint'(atan_lut(i));
      end
    end
    for (int k = 0; k < nq; k++) begin
      tmp = x; x = -y; y = tmp;
    end
    xo = clamp16(shift_floor(x + (1 << 14), 15));
    yo = clamp16(shift_floor(y + (1 << 14), 15));
    hz = 0;
    if (hemi) begin
      rad = (64'sd1 << 30) - xo * xo - yo * yo;
      if (rad > 0) begin
        hz = int_sqrt(rad);
        if (hz > 32767) hz = 32767;
      end
    end
    pt.x = xo[15:0];
    pt.y = yo[15:0];
    pt.z = hz[14:0];
    return pt;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    mismatches++;
  endtask

  // Send one sample, idling in bursts beforehand unless calm
  task automatic send_sample(logic [15:0] u, logic [15:0] v, bit known, disk_pt_t pt);
    if (!calm && $urandom_range(3) == 0) repeat ($urandom_range(1, 4)) @(negedge clk_i);
    sample_u_i = u;
    sample_v_i = v;
    in_valid_i = 1'b1;
    pending_pts.push_back(known ? pt : map_to_disk(u, v, hemi_bit));
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic drain_and_write(logic val);
    while (pending_pts.size() != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
    cfg_wdata_i <= val;
    cfg_we_i    <= 1'b1;
    hemi_bit = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off while the sender keeps going
  always @(negedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else if (hold_out) out_ready_i <= 1'b0;
    else if (!calm && $urandom_range(4) == 0) out_ready_i <= 1'b0;
    else out_ready_i <= 1'b1;
  end

  always @(posedge clk_i) begin
    disk_pt_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        idle_cycles <= 0;
        if (pending_pts.size() == 0) begin
          report_mismatch("unexpected transfer out", disk_x_o, 0);
        end else begin
          want = pending_pts.pop_front();
          if (disk_x_o !== want.x) report_mismatch("disk_x", disk_x_o, want.x);
          if (disk_y_o !== want.y) report_mismatch("disk_y", disk_y_o, want.y);
          if (lift_z_o !== want.z) report_mismatch("lift_z", lift_z_o, want.z);
        end
      end else if (in_valid_i && in_ready_o) begin
        idle_cycles <= 0;
      end else if (!drive_done || pending_pts.size() != 0) begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit) begin
          $display("concentric_disk_map_unit regression: fail");
          $finish;
        end
      end
    end
  end

  stim_row_t rows[$];

  task automatic run_directed(logic hemi);
    disk_pt_t known;
    rows = {};
    // center: zero point, full height in hemisphere mode
    known = '{x: 16'sd0, y: 16'sd0, z: hemi ? 15'd32767 : 15'd0};
    rows.push_back('{16'h8000, 16'h8000, 1'b1, known});
    rows.push_back('{16'h0000, 16'h0000, 1'b0, '0});
    rows.push_back('{16'hFFFF, 16'hFFFF, 1'b0, '0});
    rows.push_back('{16'h0000, 16'hFFFF, 1'b0, '0});
    rows.push_back('{16'hFFFF, 16'h0000, 1'b0, '0});
    rows.push_back('{16'hFFFF, 16'h8000, 1'b0, '0});
    rows.push_back('{16'h8000, 16'hFFFF, 1'b0, '0});
    rows.push_back('{16'h0000, 16'h8000, 1'b0, '0});
    rows.push_back('{16'h8000, 16'h0000, 1'b0, '0});
    // wedge borders: diagonals and anti-diagonals, plus points beside the center
    rows.push_back('{16'hC000, 16'hC000, 1'b0, '0});
    rows.push_back('{16'h4000, 16'h4000, 1'b0, '0});
    rows.push_back('{16'hC000, 16'h4000, 1'b0, '0});
    rows.push_back('{16'h4000, 16'hC000, 1'b0, '0});
    rows.push_back('{16'h8001, 16'h8000, 1'b0, '0});
    rows.push_back('{16'h7FFF, 16'h8000, 1'b0, '0});
    rows.push_back('{16'h8000, 16'h7FFF, 1'b0, '0});
    rows.push_back('{16'h5555, 16'hAAAA, 1'b0, '0});
    rows.push_back('{16'hAAAA, 16'h5555, 1'b0, '0});
    foreach (rows[i]) send_sample(rows[i].u, rows[i].v, rows[i].known, rows[i].pt);
  endtask

  task automatic run_random(int count);
    logic [15:0] u, v;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: begin
          u = 16'($urandom_range(16'hFFFF)); v = u;
        end
        1: begin
          u = 16'($urandom_range(16'hFFFF)); v = 16'hFFFF - u + 16'd1;
        end
        default: begin
          u = 16'($urandom_range(16'hFFFF)); v = 16'($urandom_range(16'hFFFF));
        end
      endcase
      send_sample(u, v, 1'b0, '0);
    end
  endtask

  initial begin
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'b0;
    in_valid_i  = 1'b0;
    sample_u_i  = '0;
    sample_v_i  = '0;
    out_ready_i = 1'b0;
    rst_ni      = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    run_directed(1'b0);
    run_random(120);
    drain_and_write(1'b1);
    run_directed(1'b1);
    // hold the output off long enough to fill the pipe and stall the input
    fork
      begin
        hold_out = 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        hold_out = 1'b0;
      end
      run_random(150);
    join
    drain_and_write(1'b0);
    run_random(100);
    drain_and_write(1'b1);
    run_random(60);
    calm = 1'b1;
    run_random(80);
    drive_done = 1'b1;

    while (pending_pts.size() != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("concentric_disk_map_unit regression: pass");
    end else begin
      $display("concentric_disk_map_unit regression: fail");
    end
    $finish;
  end

endmodule
